// ----- sv/cb40_pkg.sv -----
// ============================================================================
// cb40_pkg - shared types, constants and functions of the base-40 codec
// Holds the alphabet mapping both ways, the powers of the radix and the
// constant divide-by-40 helper used by every digit stage of the decoder.
// ============================================================================
package cb40_pkg;

    localparam int unsigned CodeW       = 48;
    localparam int unsigned CharW       = 8;
    localparam int unsigned DigitW      = 6;
    localparam int unsigned LenW        = 4;
    localparam int unsigned FieldChars  = 9;
    localparam int unsigned MaxCharsDef = 9;
    localparam int unsigned Radix       = 40;

    // Reciprocal of five scaled by 2^34; exact for every dividend below 2^32.
    localparam logic [31:0] Recip5      = 32'hCCCC_CCCD;

    // Named alphabet characters.
    localparam logic [CharW-1:0] ChSpace = 8'h20;
    localparam logic [CharW-1:0] ChDash  = 8'h2D;
    localparam logic [CharW-1:0] ChSlash = 8'h2F;
    localparam logic [CharW-1:0] ChDot   = 8'h2E;
    localparam logic [CharW-1:0] ChUpA   = 8'h41;
    localparam logic [CharW-1:0] ChUpZ   = 8'h5A;
    localparam logic [CharW-1:0] ChZero  = 8'h30;
    localparam logic [CharW-1:0] ChNine  = 8'h39;

    // Digit values of the characters that do not form a run.
    localparam logic [DigitW-1:0] DigDash  = 6'd37;
    localparam logic [DigitW-1:0] DigSlash = 6'd38;
    localparam logic [DigitW-1:0] DigDot   = 6'd39;

    typedef logic [CodeW-1:0]  t_code;
    typedef logic [CharW-1:0]  t_char;
    typedef logic [DigitW-1:0] t_digit;

    // What the decoder lanes found for one item.
    typedef struct packed {
        logic [FieldChars-1:0][DigitW-1:0] digit;
        logic [FieldChars-1:0]             nz;
        logic                              invalid;
        t_code                             code;
    } t_dec_info;

    // Radix power 40^k, used with constant arguments only.
    function automatic t_code pow40(input int unsigned k);
        t_code p;
        p = t_code'(1);
        for (int unsigned j = 0; j < k; j++) begin
            p = t_code'(p * t_code'(Radix));
        end
        return p;
    endfunction

    // ASCII character to digit value; anything outside the alphabet is zero.
    function automatic t_digit char_value(input t_char c);
        t_digit v;
        v = '0;
        if (c inside {[ChUpA:ChUpZ]}) begin
            v = DigitW'(c - ChUpA + 8'd1);
        end else if (c inside {[ChZero:ChNine]}) begin
            v = DigitW'(c - ChZero + 8'd27);
        end else if (c == ChDash) begin
            v = DigDash;
        end else if (c == ChSlash) begin
            v = DigSlash;
        end else if (c == ChDot) begin
            v = DigDot;
        end
        return v;
    endfunction

    // Digit value to ASCII character.
    function automatic t_char digit_char(input t_digit d);
        t_char c;
        c = '0;
        if (d == '0) begin
            c = ChSpace;
        end else if (d inside {[6'd1:6'd26]}) begin
            c = CharW'(ChUpA + CharW'(d) - 8'd1);
        end else if (d inside {[6'd27:6'd36]}) begin
            c = CharW'(ChZero + CharW'(d) - 8'd27);
        end else if (d == DigDash) begin
            c = ChDash;
        end else if (d == DigSlash) begin
            c = ChSlash;
        end else if (d == DigDot) begin
            c = ChDot;
        end
        return c;
    endfunction

    // Quotient of a 30-bit value by 40: drop three bits, then multiply by 1/5.
    function automatic logic [23:0] div40(input logic [29:0] x);
        logic [58:0] p;
        p = 59'(x[29:3]) * 59'(Recip5);
        return p[57:34];
    endfunction

endpackage

// ----- sv/cb40_enc.sv -----
// ============================================================================
// cb40_enc - text to code lanes
// One lane per character maps it to its digit value and weight; a two-level
// adder tree merges the weighted lanes. The final three-way add is left
// combinational for the register in the top level.
// ============================================================================
module cb40_enc
    import cb40_pkg::*;
#(
    parameter int unsigned MAX_CHARS = MaxCharsDef
) (
    input  logic                             i_clk,
    input  logic [FieldChars-1:0][CharW-1:0] i_chars,
    input  logic [LenW-1:0]                  i_len,
    output t_code                            o_sum
);

    localparam int unsigned Groups = FieldChars / 3;

    t_code            r_term [FieldChars];
    t_code            n_term [FieldChars];
    t_code            r_part [Groups];
    logic [LenW-1:0]  w_len_sat;
    logic [FieldChars-1:0] w_keep;

    // Saturate the length and find which characters take part.
    always_comb begin
        logic run;
        run = 1'b1;
        w_len_sat = (i_len > LenW'(MAX_CHARS)) ? LenW'(MAX_CHARS) : i_len;
        for (int i = 0; i < FieldChars; i++) begin
            run = run && (LenW'(i) < w_len_sat) && (i_chars[i] != '0);
            w_keep[i] = run;
        end
    end

    // Each lane weights its digit by its power of the radix.
    always_comb begin
        for (int i = 0; i < FieldChars; i++) begin
            n_term[i] = w_keep[i] ?
                t_code'(t_code'(char_value(i_chars[i])) * pow40(i)) : '0;
        end
    end

    // First level of the merge tree: groups of three lanes.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < FieldChars; i++) begin
            r_term[i] <= n_term[i];
        end
        for (int g = 0; g < Groups; g++) begin
            r_part[g] <= r_term[3*g] + r_term[3*g+1] + r_term[3*g+2];
        end
    end

    // Second level of the tree; the sum never exceeds 40^9 - 1.
    assign o_sum = r_part[0] + r_part[1] + r_part[2];

endmodule

// ----- sv/cb40_step.sv -----
// ============================================================================
// cb40_step - one base-40 digit stage
// Divides the running quotient by 40 in two registered halves: the upper 24
// bits first, then the remainder joined to the lower 24 bits. The digit of
// this lane is written into the travelling lane record.
// ============================================================================
module cb40_step
    import cb40_pkg::*;
#(
    parameter int unsigned LANE = 0
) (
    input  logic      i_clk,
    input  t_code     i_rest,
    input  t_dec_info i_info,
    output t_code     o_quot,
    output t_dec_info o_info
);

    logic [23:0]       r_qh;
    logic [DigitW-1:0] r_hl;
    logic [23:0]       r_lo;
    logic              r_nz_a;
    t_dec_info         r_info_a;

    t_code             r_quot;
    logic [DigitW-1:0] r_vl;
    logic [DigitW-1:0] r_ql6;
    logic              r_nz_b;
    t_dec_info         r_info_b;

    logic [DigitW-1:0] w_rh;
    logic [29:0]       w_v;
    logic [23:0]       w_ql;
    logic [DigitW-1:0] w_digit;

    // Upper half: quotient of the top 24 bits.
    always_ff @(posedge i_clk) begin
        r_qh     <= div40({6'd0, i_rest[47:24]});
        r_hl     <= i_rest[29:24];
        r_lo     <= i_rest[23:0];
        r_nz_a   <= (i_rest != '0);
        r_info_a <= i_info;
    end

    // Remainder of the upper half is below 40, so six bits suffice.
    assign w_rh = DigitW'(r_hl - DigitW'(r_qh[5:0] * 6'd40));
    assign w_v  = {w_rh, r_lo};
    assign w_ql = div40(w_v);

    // Lower half: the remainder carried into the low 24 bits.
    always_ff @(posedge i_clk) begin
        r_quot   <= {r_qh, w_ql};
        r_vl     <= w_v[5:0];
        r_ql6    <= w_ql[5:0];
        r_nz_b   <= r_nz_a;
        r_info_b <= r_info_a;
    end

    assign w_digit = DigitW'(r_vl - DigitW'(r_ql6 * 6'd40));
    assign o_quot  = r_quot;

    // Record this lane's digit and whether it was produced.
    always_comb begin
        o_info             = r_info_b;
        o_info.digit[LANE] = w_digit;
        o_info.nz[LANE]    = r_nz_b;
    end

endmodule

// ----- sv/cb40_dec.sv -----
// ============================================================================
// cb40_dec - code to digit lanes
// Range check on entry, then a chain of digit stages, one per character
// lane. Lanes past MAX_CHARS stay empty.
// ============================================================================
module cb40_dec
    import cb40_pkg::*;
#(
    parameter int unsigned MAX_CHARS = MaxCharsDef
) (
    input  logic      i_clk,
    input  t_code     i_code,
    output t_dec_info o_info
);

    localparam t_code CodeLimit = t_code'(pow40(MAX_CHARS) - t_code'(1));

    t_code     r_rest;
    t_dec_info r_info;
    logic      w_invalid;
    t_code     w_rest [MAX_CHARS];
    t_dec_info w_info [MAX_CHARS+1];

    assign w_invalid = (i_code > CodeLimit);

    // Entry stage: an out-of-range code decodes as an empty string.
    always_ff @(posedge i_clk) begin
        r_rest         <= w_invalid ? '0 : i_code;
        r_info.digit   <= '0;
        r_info.nz      <= '0;
        r_info.invalid <= w_invalid;
        r_info.code    <= w_invalid ? '0 : i_code;
    end

    assign w_rest[0] = r_rest;
    assign w_info[0] = r_info;

    // Digit lanes, least significant digit first.
    for (genvar i = 0; i < MAX_CHARS; i++) begin : g_lane
        if (i < MAX_CHARS - 1) begin : g_mid
            cb40_step #(.LANE(i)) u_step (
                .i_clk  (i_clk),
                .i_rest (w_rest[i]),
                .i_info (w_info[i]),
                .o_quot (w_rest[i+1]),
                .o_info (w_info[i+1])
            );
        end else begin : g_last
            cb40_step #(.LANE(i)) u_step (
                .i_clk  (i_clk),
                .i_rest (w_rest[i]),
                .i_info (w_info[i]),
                .o_quot (),
                .o_info (w_info[i+1])
            );
        end
    end

    assign o_info = w_info[MAX_CHARS];

endmodule

// ----- sv/callsign_base40_codec.sv -----
// ============================================================================
// callsign_base40_codec - callsign text to base-40 code and back
// Encodes up to nine callsign characters into a 48-bit code, or decodes a
// code into characters, with one result beat for every command beat.
// ============================================================================
// A command beat is taken whenever start is high and busy is low; busy is
// high only during reset and for the cycle after it, so one command can be
// issued every clock. Each command returns exactly one result beat on
// o_valid, which lasts one cycle. A result passes the decoder's entry
// register, its chain of digit stages, two registered halves of a divide by
// 40 for each character, and the output register; encode commands are
// delayed to match so results leave in command order. The result is not
// held: the receiver must take it in the cycle it is shown.
// ============================================================================
module callsign_base40_codec
    import cb40_pkg::*;
#(
    parameter int unsigned MAX_CHARS = MaxCharsDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_action,
    input  logic [CharW-1:0]  i_char_0,
    input  logic [CharW-1:0]  i_char_1,
    input  logic [CharW-1:0]  i_char_2,
    input  logic [CharW-1:0]  i_char_3,
    input  logic [CharW-1:0]  i_char_4,
    input  logic [CharW-1:0]  i_char_5,
    input  logic [CharW-1:0]  i_char_6,
    input  logic [CharW-1:0]  i_char_7,
    input  logic [CharW-1:0]  i_char_8,
    input  logic [LenW-1:0]   i_text_length,
    input  logic [CodeW-1:0]  i_code_in,
    output logic              o_valid,
    output logic [CodeW-1:0]  o_code_out,
    output logic [CharW-1:0]  o_out_char_0,
    output logic [CharW-1:0]  o_out_char_1,
    output logic [CharW-1:0]  o_out_char_2,
    output logic [CharW-1:0]  o_out_char_3,
    output logic [CharW-1:0]  o_out_char_4,
    output logic [CharW-1:0]  o_out_char_5,
    output logic [CharW-1:0]  o_out_char_6,
    output logic [CharW-1:0]  o_out_char_7,
    output logic [CharW-1:0]  o_out_char_8,
    output logic [LenW-1:0]   o_out_length,
    output logic              o_invalid
);

    localparam int unsigned PipeLen = 2 * MAX_CHARS + 2;
    localparam int unsigned EncDly  = 2 * MAX_CHARS - 2;

    logic                             r_busy;
    logic                             w_accept;
    logic [PipeLen-1:0]               r_vld;
    logic [PipeLen-1:0]               r_act;
    logic [FieldChars-1:0][CharW-1:0] r_in_chars;
    logic [LenW-1:0]                  r_in_len;
    t_code                            r_in_code;

    t_code                            w_enc_sum;
    t_code                            r_enc_dly [EncDly+1];
    t_dec_info                        w_dec;

    logic [FieldChars-1:0][CharW-1:0] n_chars;
    logic [LenW-1:0]                  n_len;

    logic                             r_out_valid;
    t_code                            r_out_code;
    logic [FieldChars-1:0][CharW-1:0] r_out_chars;
    logic [LenW-1:0]                  r_out_len;
    logic                             r_out_invalid;

    assign w_accept = start && !busy;
    assign busy     = r_busy;

    // Control: busy after reset, and the beat markers along the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b1;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= 1'b0;
            r_vld       <= {r_vld[PipeLen-2:0], w_accept};
            r_out_valid <= r_vld[PipeLen-1];
        end
    end

    // Command payload registers.
    always_ff @(posedge i_clk) begin
        r_act <= {r_act[PipeLen-2:0], i_action};
        if (w_accept) begin
            r_in_chars <= {i_char_8, i_char_7, i_char_6, i_char_5, i_char_4,
                           i_char_3, i_char_2, i_char_1, i_char_0};
            r_in_len   <= i_text_length;
            r_in_code  <= i_code_in;
        end
    end

    cb40_enc #(.MAX_CHARS(MAX_CHARS)) u_enc (
        .i_clk   (i_clk),
        .i_chars (r_in_chars),
        .i_len   (r_in_len),
        .o_sum   (w_enc_sum)
    );

    cb40_dec #(.MAX_CHARS(MAX_CHARS)) u_dec (
        .i_clk  (i_clk),
        .i_code (r_in_code),
        .o_info (w_dec)
    );

    // Encoder result waits until the decoder chain has caught up.
    always_ff @(posedge i_clk) begin
        r_enc_dly[0] <= w_enc_sum;
        for (int k = 1; k <= EncDly; k++) begin
            r_enc_dly[k] <= r_enc_dly[k-1];
        end
    end

    // Merge the decoder lanes into characters and a count.
    always_comb begin
        for (int i = 0; i < FieldChars; i++) begin
            n_chars[i] = w_dec.nz[i] ? digit_char(w_dec.digit[i]) : '0;
        end
        n_len = LenW'($countones(w_dec.nz));
    end

    // Output register; a result beat is shown for one cycle.
    always_ff @(posedge i_clk) begin
        if (r_vld[PipeLen-1]) begin
            if (r_act[PipeLen-1]) begin
                r_out_code    <= w_dec.code;
                r_out_chars   <= n_chars;
                r_out_len     <= n_len;
                r_out_invalid <= w_dec.invalid;
            end else begin
                r_out_code    <= r_enc_dly[EncDly];
                r_out_chars   <= '0;
                r_out_len     <= '0;
                r_out_invalid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_code_out   = r_out_code;
    assign o_out_char_0 = r_out_chars[0];
    assign o_out_char_1 = r_out_chars[1];
    assign o_out_char_2 = r_out_chars[2];
    assign o_out_char_3 = r_out_chars[3];
    assign o_out_char_4 = r_out_chars[4];
    assign o_out_char_5 = r_out_chars[5];
    assign o_out_char_6 = r_out_chars[6];
    assign o_out_char_7 = r_out_chars[7];
    assign o_out_char_8 = r_out_chars[8];
    assign o_out_length = r_out_len;
    assign o_invalid    = r_out_invalid;

endmodule

// ----- sv/cb40_checker.sv -----
// ============================================================================
// cb40_checker - port-level checks of the base-40 codec
// Watches command and result beats at the top level: one result per
// command at fixed latency, and the shape of encode and invalid results.
// ============================================================================
module cb40_checker
    import cb40_pkg::*;
#(
    parameter int unsigned MAX_CHARS = MaxCharsDef
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             i_action,
    input logic [CodeW-1:0] i_code_in,
    input logic             o_valid,
    input logic [CodeW-1:0] o_code_out,
    input logic [CharW-1:0] o_out_char_0,
    input logic [LenW-1:0]  o_out_length,
    input logic             o_invalid
);

    localparam int unsigned Lat = 2 * MAX_CHARS + 3;

    // Every command beat yields a result beat at the fixed latency.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##Lat o_valid)
        else $error("command beat without a result beat");

    // No result beat appears without a command beat before it.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, Lat))
        else $error("result beat without a command beat");

    // Encode results carry no text and are never flagged.
    a_encode_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(i_action, Lat))
            |-> (!o_invalid && o_out_length == '0 && o_out_char_0 == '0))
        else $error("encode result with decode fields set");

    // An invalid code clears code, text and count.
    a_invalid_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_invalid)
            |-> (o_code_out == '0 && o_out_length == '0 && o_out_char_0 == '0))
        else $error("invalid decode result not cleared");

    // A valid decode echoes the code it was given.
    a_decode_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_action, Lat) && !o_invalid)
            |-> (o_code_out == $past(i_code_in, Lat)))
        else $error("decode result does not echo its code");

endmodule

bind callsign_base40_codec cb40_checker #(.MAX_CHARS(MAX_CHARS)) u_cb40_checker (.*);
